/* src/lzd_pkg.sv */
// ----------------------------------------------------------------------------
// LZ token decoder package
// Shared constants, controller states and the command and status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lzd_pkg;

    // History window geometry.
    localparam int WIN_DEPTH = 65536;
    localparam int WIN_AW    = $clog2(WIN_DEPTH);

    // Output beat geometry.
    localparam int BEAT_BYTES = 8;
    localparam int BYTE_IDX_W = 3;
    localparam int CNT_W      = 4;

    // Token field widths.
    localparam int LIT_W  = 8;
    localparam int DIST_W = 16;
    localparam int LEN_W  = 9;
    localparam int RUN_W  = 16;

    // Shortest copy that a token can describe.
    localparam int MIN_MATCH = 3;

    // Packed port widths.
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 112;
    localparam int M_USER_W = 2;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_COPY
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic start_copy;
        logic copy_step;
        logic emit_beat;
        logic emit_one;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_copy;
        logic beat_done;
        logic last_beat;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

/* src/lz_token_decoder.sv */
// ----------------------------------------------------------------------------
// LZ token decoder
// Usage: tokens enter on the s_axis channel, one token per item:
//   tuser = func (1 = end of stream flush), tdata = length_or_literal and
//   distance. Decoded data leaves on the m_axis channel in beats of up to
//   eight bytes; tlast marks the final beat of each token, and the copy
//   record and the distance error flag ride in tdata and tuser.
// Throughput: one token is handled at a time. A literal, a flush or a
//   distance error is accepted, then loaded into the output register. A
//   copy reads the window memory one byte per cycle within a beat; between
//   beats it waits for the registered read of the beat's last byte and for
//   a free output register before the beat moves there.
// Reset: the window counters and the literal run return to zero and the
//   output register empties; the window memory itself is not cleared.
// Stalls: the output register holds a finished beat until m_axis_tready; the
//   decoder waits for it before loading the next beat, and s_axis_tready is
//   high only between tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module lz_token_decoder (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: length_or_literal [7:0], distance [23:8]
    input  wire logic [lzd_pkg::S_DATA_W-1:0] s_axis_tdata,
    // tuser: func [0]
    input  wire logic                         s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // tdata: out_bytes [63:0], byte_count [67:64], literal_run [83:68],
    //        copy_length [92:84], copy_distance [108:93], zero [111:109]
    output logic      [lzd_pkg::M_DATA_W-1:0] m_axis_tdata,
    // tuser: record_valid [0], distance_error [1]
    output logic      [lzd_pkg::M_USER_W-1:0] m_axis_tuser,
    output logic                              m_axis_tlast
);

    lzd_pkg::t_cmd    cmd;
    lzd_pkg::t_status status;

    lzd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lzd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_func   (s_axis_tuser),
        .i_in_lit    (s_axis_tdata[lzd_pkg::LIT_W-1:0]),
        .i_in_dist   (s_axis_tdata[lzd_pkg::LIT_W +: lzd_pkg::DIST_W]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

/* src/lzd_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered and shows
// the old contents when the same address is written in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lzd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* src/lzd_ctrl.sv */
// ----------------------------------------------------------------------------
// LZ token decoder controller
// Sequences one token at a time: accept, classify, then either a single
// result beat or a copy that runs beat by beat through the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module lzd_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    input  wire lzd_pkg::t_status i_status,
    output lzd_pkg::t_cmd         o_cmd
);

    lzd_pkg::t_state r_state;
    lzd_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lzd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            lzd_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = lzd_pkg::ST_EXEC;
                end
            end
            lzd_pkg::ST_EXEC: begin
                if (i_status.is_copy) begin
                    o_cmd.start_copy = 1'b1;
                    n_state          = lzd_pkg::ST_COPY;
                end else if (i_status.out_free) begin
                    o_cmd.emit_one = 1'b1;
                    n_state        = lzd_pkg::ST_IDLE;
                end
            end
            lzd_pkg::ST_COPY: begin
                o_cmd.copy_step = 1'b1;
                if (i_status.beat_done && i_status.out_free) begin
                    o_cmd.emit_beat = 1'b1;
                    if (i_status.last_beat) begin
                        n_state = lzd_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = lzd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/lzd_datapath.sv */
// ----------------------------------------------------------------------------
// LZ token decoder datapath
// Holds the token, the history window, the window counters, the beat assembly
// register and the output register. Copies move one byte per cycle within a
// beat through the window memory, with forwarding of the byte just written.
// ----------------------------------------------------------------------------
`default_nettype none

module lzd_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire lzd_pkg::t_cmd                 i_cmd,
    output lzd_pkg::t_status                   o_status,
    input  wire logic                          i_in_func,
    input  wire logic [lzd_pkg::LIT_W-1:0]     i_in_lit,
    input  wire logic [lzd_pkg::DIST_W-1:0]    i_in_dist,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic      [lzd_pkg::M_DATA_W-1:0]  o_out_data,
    output logic      [lzd_pkg::M_USER_W-1:0]  o_out_user,
    output logic                               o_out_last
);

    // Latched token.
    logic                          r_func,  n_func;
    logic [lzd_pkg::LIT_W-1:0]     r_lit,   n_lit;
    logic [lzd_pkg::DIST_W-1:0]    r_dist,  n_dist;

    // Window counters.
    logic [lzd_pkg::WIN_AW-1:0]    r_wp,    n_wp;
    logic [lzd_pkg::WIN_AW:0]      r_prod,  n_prod;
    logic [lzd_pkg::RUN_W-1:0]     r_run,   n_run;

    // Copy engine.
    logic [lzd_pkg::WIN_AW-1:0]    r_rp,        n_rp;
    logic [lzd_pkg::LEN_W-1:0]     r_left,      n_left;
    logic [lzd_pkg::CNT_W-1:0]     r_beat_left, n_beat_left;
    logic                          r_pend,      n_pend;
    logic                          r_fwd,       n_fwd;
    logic [7:0]                    r_fwd_byte,  n_fwd_byte;

    // Beat assembly.
    logic [lzd_pkg::BEAT_BYTES-1:0][7:0] r_word, n_word;
    logic [lzd_pkg::CNT_W-1:0]           r_cnt,  n_cnt;

    // Output register.
    logic                          r_ov,    n_ov;
    logic [63:0]                   r_obytes, n_obytes;
    logic [lzd_pkg::CNT_W-1:0]     r_ocnt,  n_ocnt;
    logic                          r_olast, n_olast;
    logic                          r_orv,   n_orv;
    logic [lzd_pkg::RUN_W-1:0]     r_orun,  n_orun;
    logic [lzd_pkg::LEN_W-1:0]     r_olen,  n_olen;
    logic [lzd_pkg::DIST_W-1:0]    r_odist, n_odist;
    logic                          r_oerr,  n_oerr;

    // Memory port signals.
    logic                          ram_we;
    logic [lzd_pkg::WIN_AW-1:0]    ram_waddr;
    logic [7:0]                    ram_wdata;
    logic [7:0]                    ram_rdata;

    logic                          issue;
    logic                          consume;
    logic [7:0]                    byte_in;
    logic [lzd_pkg::LEN_W-1:0]     copy_len;
    logic                          out_free;
    logic [lzd_pkg::CNT_W-1:0]     next_beat;

    lzd_ram #(
        .WIDTH (8),
        .DEPTH (lzd_pkg::WIN_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rp),
        .o_rdata (ram_rdata)
    );

    // Status toward the controller.
    always_comb begin
        out_free           = !r_ov || i_out_ready;
        o_status.out_free  = out_free;
        o_status.is_copy   = !r_func && (r_dist != '0)
                             && ({1'b0, r_dist} <= (lzd_pkg::DIST_W + 1)'(r_prod));
        o_status.beat_done = (r_beat_left == '0) && !r_pend;
        o_status.last_beat = (r_left == '0);
    end

    // Next values of the datapath registers.
    always_comb begin
        n_func      = r_func;
        n_lit       = r_lit;
        n_dist      = r_dist;
        n_wp        = r_wp;
        n_prod      = r_prod;
        n_run       = r_run;
        n_rp        = r_rp;
        n_left      = r_left;
        n_beat_left = r_beat_left;
        n_word      = r_word;
        n_cnt       = r_cnt;
        n_obytes    = r_obytes;
        n_ocnt      = r_ocnt;
        n_olast     = r_olast;
        n_orv       = r_orv;
        n_orun      = r_orun;
        n_olen      = r_olen;
        n_odist     = r_odist;
        n_oerr      = r_oerr;
        n_ov        = r_ov && !i_out_ready;

        copy_len  = lzd_pkg::LEN_W'(r_lit) + lzd_pkg::LEN_W'(lzd_pkg::MIN_MATCH);
        next_beat = (r_left < lzd_pkg::LEN_W'(lzd_pkg::BEAT_BYTES))
                    ? r_left[lzd_pkg::CNT_W-1:0] : lzd_pkg::CNT_W'(lzd_pkg::BEAT_BYTES);

        issue   = i_cmd.copy_step && (r_beat_left != '0);
        consume = r_pend;
        byte_in = r_fwd ? r_fwd_byte : ram_rdata;

        ram_we    = 1'b0;
        ram_waddr = r_wp;
        ram_wdata = byte_in;

        // Take a new token.
        if (i_cmd.load) begin
            n_func = i_in_func;
            n_lit  = i_in_lit;
            n_dist = i_in_dist;
        end

        // Set up a copy: the read pointer trails the write pointer by the distance.
        if (i_cmd.start_copy) begin
            n_rp        = r_wp - r_dist[lzd_pkg::WIN_AW-1:0];
            n_left      = copy_len;
            n_beat_left = (copy_len < lzd_pkg::LEN_W'(lzd_pkg::BEAT_BYTES))
                          ? copy_len[lzd_pkg::CNT_W-1:0]
                          : lzd_pkg::CNT_W'(lzd_pkg::BEAT_BYTES);
            n_word      = '0;
            n_cnt       = '0;
        end

        // Issue the read of the next copy byte.
        if (issue) begin
            n_rp        = r_rp + lzd_pkg::WIN_AW'(1);
            n_left      = r_left - lzd_pkg::LEN_W'(1);
            n_beat_left = r_beat_left - lzd_pkg::CNT_W'(1);
        end

        // The byte read last cycle is written back and packed into the beat.
        if (consume) begin
            ram_we                          = 1'b1;
            n_wp                            = r_wp + lzd_pkg::WIN_AW'(1);
            n_word[r_cnt[lzd_pkg::BYTE_IDX_W-1:0]] = byte_in;
            n_cnt                           = r_cnt + lzd_pkg::CNT_W'(1);
            if (r_prod < (lzd_pkg::WIN_AW + 1)'(lzd_pkg::WIN_DEPTH)) begin
                n_prod = r_prod + (lzd_pkg::WIN_AW + 1)'(1);
            end
        end

        // A read of the slot written in the same cycle takes the written byte.
        n_pend     = issue;
        n_fwd      = issue && consume && (r_wp == r_rp);
        n_fwd_byte = byte_in;

        // Hand a finished copy beat to the output register.
        if (i_cmd.emit_beat) begin
            n_ov        = 1'b1;
            n_obytes    = r_word;
            n_ocnt      = r_cnt;
            n_olast     = (r_left == '0);
            n_orv       = (r_left == '0);
            n_orun      = (r_left == '0) ? r_run : '0;
            n_olen      = (r_left == '0) ? copy_len : '0;
            n_odist     = (r_left == '0) ? r_dist : '0;
            n_oerr      = 1'b0;
            n_word      = '0;
            n_cnt       = '0;
            n_beat_left = next_beat;
            if (r_left == '0) begin
                n_run = '0;
            end
        end

        // Single-beat results: flush, literal or distance error.
        if (i_cmd.emit_one) begin
            n_ov     = 1'b1;
            n_obytes = '0;
            n_ocnt   = '0;
            n_olast  = 1'b1;
            n_orv    = 1'b0;
            n_orun   = '0;
            n_olen   = '0;
            n_odist  = '0;
            n_oerr   = 1'b0;
            priority if (r_func) begin
                n_orv  = (r_run != '0);
                n_orun = r_run;
                n_run  = '0;
                n_wp   = '0;
                n_prod = '0;
            end else if (r_dist == '0) begin
                n_obytes  = 64'(r_lit);
                n_ocnt    = lzd_pkg::CNT_W'(1);
                ram_we    = 1'b1;
                ram_wdata = r_lit;
                n_wp      = r_wp + lzd_pkg::WIN_AW'(1);
                if (r_prod < (lzd_pkg::WIN_AW + 1)'(lzd_pkg::WIN_DEPTH)) begin
                    n_prod = r_prod + (lzd_pkg::WIN_AW + 1)'(1);
                end
                if (r_run != '1) begin
                    n_run = r_run + lzd_pkg::RUN_W'(1);
                end
            end else begin
                n_oerr = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_prod      <= '0;
            r_run       <= '0;
            r_pend      <= 1'b0;
            r_fwd       <= 1'b0;
            r_beat_left <= '0;
            r_left      <= '0;
            r_ov        <= 1'b0;
            r_func      <= 1'b0;
        end else begin
            r_wp        <= n_wp;
            r_prod      <= n_prod;
            r_run       <= n_run;
            r_pend      <= n_pend;
            r_fwd       <= n_fwd;
            r_beat_left <= n_beat_left;
            r_left      <= n_left;
            r_ov        <= n_ov;
            r_func      <= n_func;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_lit      <= n_lit;
        r_dist     <= n_dist;
        r_rp       <= n_rp;
        r_fwd_byte <= n_fwd_byte;
        r_word     <= n_word;
        r_cnt      <= n_cnt;
        r_obytes   <= n_obytes;
        r_ocnt     <= n_ocnt;
        r_olast    <= n_olast;
        r_orv      <= n_orv;
        r_orun     <= n_orun;
        r_olen     <= n_olen;
        r_odist    <= n_odist;
        r_oerr     <= n_oerr;
    end

    // Output packing.
    assign o_out_valid = r_ov;
    assign o_out_last  = r_olast;
    assign o_out_data  = {3'b000, r_odist, r_olen, r_orun, r_ocnt, r_obytes};
    assign o_out_user  = {r_oerr, r_orv};

endmodule

`default_nettype wire
